// ===== sv/mma_pkg.sv =====
// ----------------------------------------------------------------------------
// mma_pkg
// shared types, codes and status decode for the midi message assembler
// ----------------------------------------------------------------------------
package mma_pkg;

  // request codes
  localparam logic REQ_RECV  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  // command kinds passed from front to back
  localparam logic CMD_RT    = 1'b0;   // one byte carried in the command
  localparam logic CMD_STORE = 1'b1;   // run of bytes read from the buffer

  // midi byte codes
  localparam logic [7:0] ST_NOTE_OFF  = 8'h80;
  localparam logic [7:0] ST_PROG      = 8'hC0;
  localparam logic [7:0] ST_PBEND     = 8'hE0;
  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_MTC       = 8'hF1;
  localparam logic [7:0] ST_SPP       = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL  = 8'hF3;
  localparam logic [7:0] ST_ONE_FIRST = 8'hF4;
  localparam logic [7:0] ST_EOX       = 8'hF7;
  localparam logic [7:0] RT_FIRST     = 8'hF8;
  localparam logic [7:0] RT_RESET     = 8'hFF;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
  } mma_cmd_t;

  localparam int CMD_W = $bits(mma_cmd_t);

  // message length for any status other than sysex
  function automatic logic [1:0] msg_len(input logic [7:0] status);
    logic [1:0] len;
    if (status < ST_PROG && status >= ST_NOTE_OFF) len = 2'd3;
    else if (status < ST_PBEND && status >= ST_PROG) len = 2'd2;
    else if (status < ST_SYSEX && status >= ST_PBEND) len = 2'd3;
    else if (status == ST_MTC || status == ST_SONG_SEL) len = 2'd2;
    else if (status == ST_SPP) len = 2'd3;
    else len = 2'd1;
    return len;
  endfunction

endpackage

// ===== sv/midi_message_assembler.sv =====
// ----------------------------------------------------------------------------
// midi_message_assembler
// assembles a midi byte stream into complete messages with running status
// ----------------------------------------------------------------------------
// output: a realtime or one-byte message is registered into out_valid from the
//   command queue; a buffered message is read from the buffer byte by byte,
//   each byte taking a buffer read slot and then a load that waits on out_ready
// flow: in_ready drops while a buffered message drains and while the queue is
//   full; other requests are accepted while the queue has room
// reset: synchronous active-low rst_n clears count, sysex flag, queue and
//   output; buffer contents are not cleared and are never read before written
// ----------------------------------------------------------------------------
module midi_message_assembler import mma_pkg::*; #(
  parameter int MAX_MSG_BYTES = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  // request channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_req_type,
  input  logic [7:0] in_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  // count holds 0..MAX_MSG_BYTES, buffer index 0..MAX_MSG_BYTES-1
  localparam int CW = $clog2(MAX_MSG_BYTES + 1);
  localparam int AW = $clog2(MAX_MSG_BYTES);
  localparam int QW = CW + CMD_W;

  // front to queue
  logic          enq;
  mma_cmd_t      enq_cmd;
  logic [CW-1:0] enq_len;
  logic          q_full;
  // queue to back
  logic          q_pop, q_empty;
  logic [QW-1:0] q_data;
  mma_cmd_t      q_cmd;
  logic [CW-1:0] q_len;
  // buffer read port and drain handshake
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          done;

  assign q_cmd = q_data[CMD_W-1:0];
  assign q_len = q_data[QW-1:CMD_W];

  // front: classifies each request, updates running status, writes buffer
  mma_front #(
    .MAX_MSG_BYTES (MAX_MSG_BYTES),
    .CW            (CW),
    .AW            (AW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (in_req_type),
    .in_data  (in_byte),
    .enq      (enq),
    .enq_cmd  (enq_cmd),
    .enq_len  (enq_len),
    .q_full   (q_full),
    .done     (done),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  // short command queue so requests are still accepted while output stalls, until it fills
  mma_fifo #(
    .W (QW)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (enq),
    .push_data ({enq_len, enq_cmd}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  // back: emits realtime bytes directly, drains buffered messages byte by byte
  mma_back #(
    .CW (CW),
    .AW (AW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_cmd     (q_cmd),
    .q_len     (q_len),
    .q_pop     (q_pop),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .done      (done),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

// ===== sv/mma_fifo.sv =====
// ----------------------------------------------------------------------------
// mma_fifo
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module mma_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);

  logic [W-1:0] mem_r [2];
  logic         wptr_r, wptr_nxt;
  logic         rptr_r, rptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         do_push, do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem_r[rptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wptr_nxt = wptr_r ^ do_push;
    rptr_nxt = rptr_r ^ do_pop;
    cnt_nxt  = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= push_data;
  end

endmodule

// ===== sv/mma_front.sv =====
// ----------------------------------------------------------------------------
// mma_front
// accepts requests, tracks running status and sysex, owns the message buffer
// ----------------------------------------------------------------------------
module mma_front import mma_pkg::*; #(
  parameter int MAX_MSG_BYTES = 32,
  parameter int CW = 6,
  parameter int AW = 5
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            req_type,
  input  logic [7:0]      in_data,
  output logic            enq,
  output mma_cmd_t        enq_cmd,
  output logic [CW-1:0]   enq_len,
  input  logic            q_full,
  input  logic            done,
  input  logic [AW-1:0]   rd_addr,
  output logic [7:0]      rd_data
);

  localparam logic [CW-1:0] MAX_C = CW'(MAX_MSG_BYTES);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  logic [7:0]    mem_r [MAX_MSG_BYTES];
  logic [7:0]    rd_data_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          sysex_r, sysex_nxt;
  logic [7:0]    status_r, status_nxt;
  logic          busy_r, busy_nxt;
  logic          accept, store_full, eff_f0, need_emit;
  logic [CW-1:0] push_cnt;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  assign in_ready   = !busy_r && !q_full;
  assign accept     = in_valid && in_ready;
  assign store_full = (count_r == MAX_C);
  assign push_cnt   = store_full ? count_r : count_r + ONE_C;
  assign eff_f0     = sysex_r || (status_r == ST_SYSEX);
  assign need_emit  = eff_f0 ? (push_cnt == MAX_C) : (push_cnt >= CW'(msg_len(status_r)));
  assign rd_data    = rd_data_r;

  always_comb begin
    count_nxt  = count_r;
    sysex_nxt  = sysex_r;
    status_nxt = status_r;
    wr_en      = 1'b0;
    wr_addr    = count_r[AW-1:0];
    enq        = 1'b0;
    enq_cmd    = '{kind: CMD_RT, data: in_data};
    enq_len    = push_cnt;
    if (accept) begin
      if (req_type == REQ_CLEAR) begin
        count_nxt = '0;
        sysex_nxt = 1'b0;
      end else if (in_data[7]) begin
        if (in_data == ST_EOX) begin
          if (sysex_r) begin
            wr_en        = !store_full;
            enq          = 1'b1;
            enq_cmd.kind = CMD_STORE;
          end
          count_nxt = '0;
          sysex_nxt = 1'b0;
        end else if (in_data >= RT_FIRST) begin
          enq = 1'b1;
          if (in_data == RT_RESET) count_nxt = '0;
        end else if (in_data >= ST_ONE_FIRST) begin
          // one-byte system common: out at once, nothing kept
          enq       = 1'b1;
          count_nxt = '0;
          sysex_nxt = 1'b0;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = '0;
          status_nxt = in_data;
          count_nxt  = ONE_C;
          sysex_nxt  = (in_data == ST_SYSEX);
        end
      end else if (count_r != '0 || sysex_r) begin
        wr_en     = !store_full;
        count_nxt = push_cnt;
        if (need_emit) begin
          enq          = 1'b1;
          enq_cmd.kind = CMD_STORE;
          count_nxt    = (eff_f0 || status_r >= ST_SYSEX) ? '0 : ONE_C;
        end
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (done) busy_nxt = 1'b0;
    if (enq && enq_cmd.kind == CMD_STORE) busy_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sysex_r <= 1'b0;
      busy_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      sysex_r <= sysex_nxt;
      busy_r  <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= in_data;
    rd_data_r <= mem_r[rd_addr];
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !accept)
    else $error("request accepted while buffer drains");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r < MAX_C)
    else $error("buffer count at rest reached chunk size");

  a_store_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    enq && enq_cmd.kind == CMD_STORE |=> busy_r)
    else $error("buffer command queued without busy");

endmodule

// ===== sv/mma_back.sv =====
// ----------------------------------------------------------------------------
// mma_back
// pops commands and drives the result channel one byte at a time
// ----------------------------------------------------------------------------
module mma_back import mma_pkg::*; #(
  parameter int CW = 6,
  parameter int AW = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  mma_cmd_t      q_cmd,
  input  logic [CW-1:0] q_len,
  output logic          q_pop,
  output logic [AW-1:0] rd_addr,
  input  logic [7:0]    rd_data,
  output logic          done,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_last
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_LD   = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic          ov_r, ov_nxt;
  logic [7:0]    ob_r, ob_nxt;
  logic          ol_r, ol_nxt;
  logic          slot_free, is_last, load;

  assign slot_free = !ov_r || out_ready;
  assign is_last   = (CW'(idx_r) + CW'(1)) == len_r;
  assign rd_addr   = idx_r;
  assign out_valid = ov_r;
  assign out_byte  = ob_r;
  assign out_last  = ol_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    len_nxt   = len_r;
    ov_nxt    = ov_r && !out_ready;
    ob_nxt    = ob_r;
    ol_nxt    = ol_r;
    q_pop     = 1'b0;
    done      = 1'b0;
    load      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          if (q_cmd.kind == CMD_STORE) begin
            q_pop     = 1'b1;
            idx_nxt   = '0;
            len_nxt   = q_len;
            state_nxt = ST_RD;
          end else if (slot_free) begin
            q_pop  = 1'b1;
            ov_nxt = 1'b1;
            ob_nxt = q_cmd.data;
            ol_nxt = 1'b1;
          end
        end
      end
      ST_RD: begin
        state_nxt = ST_LD;
      end
      ST_LD: begin
        if (slot_free) begin
          load   = 1'b1;
          ov_nxt = 1'b1;
          ob_nxt = rd_data;
          ol_nxt = is_last;
          if (is_last) begin
            done      = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = ST_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    len_r <= len_nxt;
    ob_r  <= ob_nxt;
    ol_r  <= ol_nxt;
  end

  a_done_in_ld: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> state_r == ST_LD && load)
    else $error("done outside of a byte load");

  a_rd_then_ld: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RD |=> state_r == ST_LD)
    else $error("read slot not followed by load");

  a_ld_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LD && !load |=> state_r == ST_LD && $stable(idx_r))
    else $error("stalled load moved on");

endmodule
